@@ design/sha256_byte_stream_hasher_macros.svh @@
// Assertion macros shared by the SHA-256 byte stream hasher RTL.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SHABS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shabs assertion failed");

// Next-cycle implication, checked outside reset.
`define SHABS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("shabs assertion failed");

`endif

@@ design/shabs_pkg.sv @@
// Shared types, constants and the round constant table of the SHA-256 hasher.
// No dependencies; imported by shabs_round and sha256_byte_stream_hasher.
`default_nettype none

package shabs_pkg;

  localparam int WORD_W  = 32;
  localparam int ROUNDS  = 64;
  localparam int RND_W   = $clog2(ROUNDS);
  localparam int FILL_W  = 6;

  // Eight working or chaining words, index 0 is word A / H0.
  typedef logic [7:0][WORD_W-1:0] word8_t;
  // Sixteen-word message window, index 15 holds the oldest word.
  typedef logic [15:0][WORD_W-1:0] block_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [FILL_W-1:0] FILL_LAST = 6'd63;
  localparam logic [2:0] LEN_ROW = 3'd7;

  localparam word8_t INIT_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_FINAL = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  // Round constants.
  function automatic logic [WORD_W-1:0] round_k(input logic [RND_W-1:0] idx);
    logic [WORD_W-1:0] k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

@@ design/shabs_round.sv @@
// One SHA-256 compression round plus one message schedule step.
// Depends on shabs_pkg; used once per cycle while the top-level sequencer runs rounds.
`default_nettype none

module shabs_round
  import shabs_pkg::*;
(
  input  wire word8_t            v,
  input  wire block_t            win,
  input  wire [RND_W-1:0]        rnd,
  output word8_t                 v_next,
  output logic [WORD_W-1:0]      w_new
);

  logic [WORD_W-1:0] big0, big1, ch, maj, t1, t2, s0, s1, w_t;

  // Schedule: the oldest window word is W[t], the new word is W[t+16].
  always_comb begin
    w_t   = win[15];
    s0    = {win[14][6:0], win[14][31:7]} ^ {win[14][17:0], win[14][31:18]} ^
            (win[14] >> 3);
    s1    = {win[1][16:0], win[1][31:17]} ^ {win[1][18:0], win[1][31:19]} ^
            (win[1] >> 10);
    w_new = s1 + win[6] + s0 + w_t;
  end

  // Round function over the working words A..H.
  always_comb begin
    big1 = {v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]} ^
           {v[4][24:0], v[4][31:25]};
    ch   = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1   = v[7] + big1 + ch + round_k(rnd) + w_t;
    big0 = {v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]} ^
           {v[0][21:0], v[0][31:22]};
    maj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2   = big0 + maj;
    v_next[7] = v[6];
    v_next[6] = v[5];
    v_next[5] = v[4];
    v_next[4] = v[3] + t1;
    v_next[3] = v[2];
    v_next[2] = v[1];
    v_next[1] = v[0];
    v_next[0] = t1 + t2;
  end

endmodule

`default_nettype wire

@@ design/sha256_byte_stream_hasher.sv @@
// Channel   | tdata fields (low bit up)             | tuser    | tlast
// s_ (in)   | data_byte[7:0]                        | has_byte | end_of_message
// m_ (out)  | digest_word[31:0], word_index[34:32]  | -        | last_word
//
// A request with a byte shifts it into the block; the 64th byte of a block
// starts the rounds on the single round unit, followed by the chaining add.
// End of message adds one padding byte per free byte of the block (up to 64,
// or 72 with a second block), one or two compressions, then 8 digest words.
// Input is not ready while padding, compressing or emitting; output stalls
// hold the word. Reset is synchronous and restores the initial hash values.
// Depends on shabs_pkg, shabs_round and sha256_byte_stream_hasher_macros.svh.
`default_nettype none

`include "sha256_byte_stream_hasher_macros.svh"

module sha256_byte_stream_hasher
  import shabs_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // data_byte[7:0]
  input  wire         s_tuser,   // has_byte
  input  wire         s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zeros
  output logic        m_tlast    // last_word
);

  state_t            state, state_next;
  word8_t            chain, chain_next;
  word8_t            v, v_next, v_round;
  block_t            blk, blk_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [63:0]       bits, bits_next;
  logic [RND_W-1:0]  rnd, rnd_next;
  logic [2:0]        idx, idx_next;
  logic              end_pend, end_pend_next;
  logic              sent80, sent80_next;
  logic              extra, extra_next;
  logic              final_blk, final_blk_next;
  logic [WORD_W-1:0] w_new;
  logic [7:0]        pad_byte;
  logic              s_acc, m_acc;

  shabs_round u_round (
    .v      (v),
    .win    (blk),
    .rnd    (rnd),
    .v_next (v_round),
    .w_new  (w_new)
  );

  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign m_tvalid = (state == ST_OUT);
  assign m_acc    = m_tvalid && m_tready;
  assign m_tdata  = {5'd0, idx, chain[0]};
  assign m_tlast  = (idx == 3'd7);

  // Padding byte: the marker, then zeros, then the big-endian bit length.
  always_comb begin
    if (!sent80) begin
      pad_byte = PAD_BYTE;
    end else if (extra || fill[5:3] != LEN_ROW) begin
      pad_byte = 8'h00;
    end else begin
      pad_byte = bits[8*(7-fill[2:0]) +: 8];
    end
  end

  // Sequencer and datapath next state.
  always_comb begin
    state_next     = state;
    chain_next     = chain;
    v_next         = v;
    blk_next       = blk;
    fill_next      = fill;
    bits_next      = bits;
    rnd_next       = rnd;
    idx_next       = idx;
    end_pend_next  = end_pend;
    sent80_next    = sent80;
    extra_next     = extra;
    final_blk_next = final_blk;
    unique case (state)
      ST_IDLE: begin
        if (s_acc) begin
          end_pend_next = s_tlast;
          if (s_tuser) begin
            blk_next  = {blk[15][23:0], blk[14:0], s_tdata};
            fill_next = fill + 1'b1;
            bits_next = bits + 64'd8;
          end
          if (s_tuser && fill == FILL_LAST) begin
            state_next = ST_ROUND;
            v_next     = chain;
            rnd_next   = '0;
          end else if (s_tlast) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        blk_next  = {blk[15][23:0], blk[14:0], pad_byte};
        fill_next = fill + 1'b1;
        if (!sent80) begin
          sent80_next = 1'b1;
          extra_next  = (fill[5:3] == LEN_ROW);
        end else if (!extra && fill == FILL_LAST) begin
          final_blk_next = 1'b1;
        end
        if (fill == FILL_LAST) begin
          extra_next = 1'b0;
          state_next = ST_ROUND;
          v_next     = chain;
          rnd_next   = '0;
        end
      end
      ST_ROUND: begin
        v_next   = v_round;
        blk_next = {blk[14:0], w_new};
        rnd_next = rnd + 1'b1;
        if (rnd == RND_W'(ROUNDS - 1)) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        for (int i = 0; i < 8; i++) begin
          chain_next[i] = chain[i] + v[i];
        end
        if (final_blk) begin
          state_next     = ST_OUT;
          idx_next       = '0;
          bits_next      = '0;
          end_pend_next  = 1'b0;
          sent80_next    = 1'b0;
          final_blk_next = 1'b0;
        end else if (end_pend) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (m_acc) begin
          chain_next = {chain[0], chain[7:1]};
          idx_next   = idx + 1'b1;
          if (idx == 3'd7) begin
            chain_next = INIT_HASH;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state and chaining words.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      chain     <= INIT_HASH;
      fill      <= '0;
      bits      <= '0;
      rnd       <= '0;
      idx       <= '0;
      end_pend  <= 1'b0;
      sent80    <= 1'b0;
      extra     <= 1'b0;
      final_blk <= 1'b0;
    end else begin
      state     <= state_next;
      chain     <= chain_next;
      fill      <= fill_next;
      bits      <= bits_next;
      rnd       <= rnd_next;
      idx       <= idx_next;
      end_pend  <= end_pend_next;
      sent80    <= sent80_next;
      extra     <= extra_next;
      final_blk <= final_blk_next;
    end
  end

  // Working words and the message window.
  always_ff @(posedge clk) begin
    v   <= v_next;
    blk <= blk_next;
  end

  // Checks on the sequencer.
  `SHABS_ASSERT_SAME(a_no_in_while_out, m_tvalid, !s_tready)
  `SHABS_ASSERT_NEXT(a_rounds_end, state == ST_ROUND && rnd == RND_W'(ROUNDS - 1),
                     state == ST_FINAL)
  `SHABS_ASSERT_SAME(a_out_clean, state == ST_OUT, fill == '0 && bits == '0)
  `SHABS_ASSERT_NEXT(a_last_to_idle, m_acc && m_tlast, state == ST_IDLE)

endmodule

`default_nettype wire
